### hdl/coupled_logistic_map_three_top_macros.svh
// ============================================================================
// Coupled logistic map assertion macros
// Shared assertion forms for the three-variable coupled logistic map block.
// Each macro samples on clk and is disabled while rst_n is low.
// ============================================================================
`ifndef COUPLED_LOGISTIC_MAP_THREE_TOP_MACROS_SVH
`define COUPLED_LOGISTIC_MAP_THREE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLM3_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLM3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/clm3_pkg.sv
// ============================================================================
// Coupled logistic map package
// Number format, item structs, codes and coefficient lookup functions for
// the three-variable coupled logistic map.
// ============================================================================
package clm3_pkg;

    // Signed fixed point: WORD_BITS total, FRACTION_BITS fractional.
    localparam int WORD_BITS     = 48;
    localparam int FRACTION_BITS = 32;
    localparam int LIMIT_BITS    = WORD_BITS - 1;

    // The multiplier splits its second operand into a low and a high half.
    localparam int LO_BITS = WORD_BITS / 2;
    localparam int HI_BITS = WORD_BITS - LO_BITS;
    localparam int MULB_W  = HI_BITS + 1;
    localparam int PROD_W  = WORD_BITS + MULB_W;
    localparam int FULL_W  = 2 * WORD_BITS;

    // Coefficient table.
    localparam int COEF_COUNT = 9;
    localparam int CIDX_W     = 4;
    localparam int VAR_COUNT  = 3;
    localparam int VIDX_W     = 2;

    // Item modes.
    localparam logic [1:0] MODE_COEF = 2'd0;
    localparam logic [1:0] MODE_LOAD = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    // Terms of one variable update, in the order they are formed.
    localparam logic [1:0] TERM_ALPHA  = 2'd0;
    localparam logic [1:0] TERM_BETA_J = 2'd1;
    localparam logic [1:0] TERM_BETA_K = 2'd2;
    localparam logic [1:0] TERM_OUTER  = 2'd3;

    localparam logic [VIDX_W-1:0] LAST_VAR  = VIDX_W'(VAR_COUNT - 1);
    localparam logic [2:0]        ALL_VALID = 3'b111;

    // Coefficient codes.
    localparam logic [CIDX_W-1:0] C_ALPHA1 = 4'd0;
    localparam logic [CIDX_W-1:0] C_ALPHA2 = 4'd1;
    localparam logic [CIDX_W-1:0] C_ALPHA3 = 4'd2;
    localparam logic [CIDX_W-1:0] C_BETA12 = 4'd3;
    localparam logic [CIDX_W-1:0] C_BETA13 = 4'd4;
    localparam logic [CIDX_W-1:0] C_BETA21 = 4'd5;
    localparam logic [CIDX_W-1:0] C_BETA23 = 4'd6;
    localparam logic [CIDX_W-1:0] C_BETA31 = 4'd7;
    localparam logic [CIDX_W-1:0] C_BETA32 = 4'd8;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [CIDX_W-1:0] coef_index;
        word_t             coef_value;
        word_t             start_first;
        word_t             start_second;
        word_t             start_third;
        logic [2:0]        start_valid;
    } in_item_t;

    typedef struct packed {
        word_t      value_first;
        word_t      value_second;
        word_t      value_third;
        logic [2:0] valid_mask;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_COMBINE,
        S_APPLY,
        S_OUT
    } state_t;

    // Growth coefficient of a variable.
    function automatic logic [CIDX_W-1:0] alpha_idx(input logic [VIDX_W-1:0] v);
        logic [CIDX_W-1:0] r;
        unique case (v)
            2'd0:    r = C_ALPHA1;
            2'd1:    r = C_ALPHA2;
            default: r = C_ALPHA3;
        endcase
        return r;
    endfunction

    // Coupling coefficient from the first other variable.
    function automatic logic [CIDX_W-1:0] beta_j_idx(input logic [VIDX_W-1:0] v);
        logic [CIDX_W-1:0] r;
        unique case (v)
            2'd0:    r = C_BETA21;
            2'd1:    r = C_BETA12;
            default: r = C_BETA13;
        endcase
        return r;
    endfunction

    // Coupling coefficient from the second other variable.
    function automatic logic [CIDX_W-1:0] beta_k_idx(input logic [VIDX_W-1:0] v);
        logic [CIDX_W-1:0] r;
        unique case (v)
            2'd0:    r = C_BETA31;
            2'd1:    r = C_BETA32;
            default: r = C_BETA23;
        endcase
        return r;
    endfunction

    // First other variable.
    function automatic logic [VIDX_W-1:0] other_j(input logic [VIDX_W-1:0] v);
        logic [VIDX_W-1:0] r;
        unique case (v)
            2'd0:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Second other variable.
    function automatic logic [VIDX_W-1:0] other_k(input logic [VIDX_W-1:0] v);
        logic [VIDX_W-1:0] r;
        unique case (v)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

### hdl/coupled_logistic_map_three_top.sv
// ============================================================================
// Coupled logistic map, three variables
// Iterates x_i <- x_i*(a_i - a_i*x_i - b_ji*x_j - b_ki*x_k) in signed fixed
// point through one shared multiplier, with coefficient and start loading.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid/in_stall  | in_data (clm3_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_data (clm3_pkg::out_item_t)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_data (escape limit)
//
// A step forms twelve products through the shared 48x25 multiplier, each
// through the states for low half, high half, combine, then subtract or
// escape check, and then loads its result from the output state. Other
// items go from idle straight to the output state.
// in_stall is high from a transfer until its result enters the output
// register, which holds it under out_stall while the block returns to idle.
// Reset clears coefficients and values to zero, marks all variables valid
// and sets the escape limit to the largest magnitude.
// ============================================================================
`include "coupled_logistic_map_three_top_macros.svh"

module coupled_logistic_map_three_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  clm3_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output clm3_pkg::out_item_t                    out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [clm3_pkg::LIMIT_BITS-1:0]        cfg_data
);

    // Architectural state.
    clm3_pkg::word_t                  coef_reg [clm3_pkg::COEF_COUNT];
    clm3_pkg::word_t                  coef_next[clm3_pkg::COEF_COUNT];
    clm3_pkg::word_t                  x_reg    [clm3_pkg::VAR_COUNT];
    clm3_pkg::word_t                  x_next   [clm3_pkg::VAR_COUNT];
    logic [2:0]                       vb_reg, vb_next;
    logic [clm3_pkg::LIMIT_BITS-1:0]  esc_reg;

    // Sequencer.
    clm3_pkg::state_t                 state_reg, state_next;
    logic [clm3_pkg::VIDX_W-1:0]      var_reg, var_next;
    logic [1:0]                       k_reg, k_next;
    logic                             bad_reg, bad_next;
    logic [2:0]                       nv_reg, nv_next;

    // Datapath registers.
    logic signed [clm3_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [clm3_pkg::PROD_W-1:0] lo_reg, lo_next;
    clm3_pkg::word_t                  q_reg, q_next;
    logic                             qovf_reg, qovf_next;
    clm3_pkg::word_t                  t_reg, t_next;
    clm3_pkg::word_t                  nxt_reg [clm3_pkg::VAR_COUNT];
    clm3_pkg::word_t                  nxt_next[clm3_pkg::VAR_COUNT];

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    clm3_pkg::out_item_t              out_data_reg, out_data_next;

    // Combinational datapath.
    clm3_pkg::word_t                     op_a, op_b;
    logic signed [clm3_pkg::MULB_W-1:0]  mul_b;
    logic signed [clm3_pkg::PROD_W-1:0]  mul_res;
    logic [clm3_pkg::FULL_W-1:0]         prod_ext, lo_ext, full_sum;
    logic [clm3_pkg::FULL_W-clm3_pkg::FRACTION_BITS-clm3_pkg::WORD_BITS:0] top_bits;
    logic [clm3_pkg::WORD_BITS:0]        diff;
    logic                                sub_ovf;
    logic [clm3_pkg::WORD_BITS-1:0]      mag;
    logic                                keep;
    clm3_pkg::word_t                     new_val;

    assign in_stall  = (state_reg != clm3_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Operand selection for the current term of the current variable.
    always_comb
    begin
        case (k_reg)
            clm3_pkg::TERM_ALPHA:
            begin
                op_a = coef_reg[clm3_pkg::alpha_idx(var_reg)];
                op_b = x_reg[var_reg];
            end
            clm3_pkg::TERM_BETA_J:
            begin
                op_a = coef_reg[clm3_pkg::beta_j_idx(var_reg)];
                op_b = x_reg[clm3_pkg::other_j(var_reg)];
            end
            clm3_pkg::TERM_BETA_K:
            begin
                op_a = coef_reg[clm3_pkg::beta_k_idx(var_reg)];
                op_b = x_reg[clm3_pkg::other_k(var_reg)];
            end
            default:
            begin
                op_a = x_reg[var_reg];
                op_b = t_reg;
            end
        endcase
    end

    // Shared multiplier: low half of op_b as unsigned, high half as signed.
    always_comb
    begin
        if (state_reg == clm3_pkg::S_MUL_HI)
        begin
            mul_b = {op_b[clm3_pkg::WORD_BITS-1],
                     op_b[clm3_pkg::WORD_BITS-1:clm3_pkg::LO_BITS]};
        end
        else
        begin
            mul_b = {{(clm3_pkg::MULB_W - clm3_pkg::LO_BITS){1'b0}},
                     op_b[clm3_pkg::LO_BITS-1:0]};
        end
    end

    assign mul_res = op_a * mul_b;

    // Recombine the halves and drop the fraction with a floor shift.
    assign prod_ext = {{(clm3_pkg::FULL_W - clm3_pkg::PROD_W){prod_reg[clm3_pkg::PROD_W-1]}},
                       prod_reg};
    assign lo_ext   = {{(clm3_pkg::FULL_W - clm3_pkg::PROD_W){lo_reg[clm3_pkg::PROD_W-1]}},
                       lo_reg};
    assign full_sum = {prod_ext[clm3_pkg::FULL_W-1-clm3_pkg::LO_BITS:0],
                       {clm3_pkg::LO_BITS{1'b0}}} + lo_ext;
    assign top_bits = full_sum[clm3_pkg::FULL_W-1:
                               clm3_pkg::FRACTION_BITS+clm3_pkg::WORD_BITS-1];

    // Running difference of the inner term, with range check.
    assign diff    = {t_reg[clm3_pkg::WORD_BITS-1], t_reg}
                   - {q_reg[clm3_pkg::WORD_BITS-1], q_reg};
    assign sub_ovf = diff[clm3_pkg::WORD_BITS] != diff[clm3_pkg::WORD_BITS-1];

    // Escape check on the finished value.
    assign mag     = q_reg[clm3_pkg::WORD_BITS-1] ? (~q_reg + 1'b1) : q_reg;
    assign keep    = !bad_reg && !qovf_reg && (mag <= {1'b0, esc_reg});
    assign new_val = keep ? q_reg : '0;

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        var_next       = var_reg;
        k_next         = k_reg;
        bad_next       = bad_reg;
        nv_next        = nv_reg;
        coef_next      = coef_reg;
        x_next         = x_reg;
        vb_next        = vb_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        q_next         = q_reg;
        qovf_next      = qovf_reg;
        t_next         = t_reg;
        nxt_next       = nxt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            clm3_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = clm3_pkg::S_OUT;
                    case (in_data.mode)
                        clm3_pkg::MODE_COEF:
                        begin
                            if (in_data.coef_index < clm3_pkg::CIDX_W'(clm3_pkg::COEF_COUNT))
                            begin
                                coef_next[in_data.coef_index] = in_data.coef_value;
                            end
                        end
                        clm3_pkg::MODE_LOAD:
                        begin
                            x_next[0] = in_data.start_valid[0] ? in_data.start_first  : '0;
                            x_next[1] = in_data.start_valid[1] ? in_data.start_second : '0;
                            x_next[2] = in_data.start_valid[2] ? in_data.start_third  : '0;
                            vb_next   = in_data.start_valid;
                        end
                        clm3_pkg::MODE_STEP:
                        begin
                            if (vb_reg == clm3_pkg::ALL_VALID)
                            begin
                                var_next   = '0;
                                k_next     = clm3_pkg::TERM_ALPHA;
                                nv_next    = '0;
                                state_next = clm3_pkg::S_MUL_LO;
                            end
                            else
                            begin
                                // One invalid variable poisons all three.
                                x_next[0] = '0;
                                x_next[1] = '0;
                                x_next[2] = '0;
                                vb_next   = '0;
                            end
                        end
                        default:
                        begin
                            state_next = clm3_pkg::S_OUT;
                        end
                    endcase
                end
            end

            clm3_pkg::S_MUL_LO:
            begin
                prod_next = mul_res;
                if (k_reg == clm3_pkg::TERM_ALPHA)
                begin
                    // The inner term starts from the growth coefficient.
                    t_next   = op_a;
                    bad_next = 1'b0;
                end
                state_next = clm3_pkg::S_MUL_HI;
            end

            clm3_pkg::S_MUL_HI:
            begin
                lo_next    = prod_reg;
                prod_next  = mul_res;
                state_next = clm3_pkg::S_COMBINE;
            end

            clm3_pkg::S_COMBINE:
            begin
                q_next     = full_sum[clm3_pkg::FRACTION_BITS+clm3_pkg::WORD_BITS-1:
                                      clm3_pkg::FRACTION_BITS];
                qovf_next  = !((&top_bits) || !(|top_bits));
                state_next = clm3_pkg::S_APPLY;
            end

            clm3_pkg::S_APPLY:
            begin
                if (k_reg != clm3_pkg::TERM_OUTER)
                begin
                    t_next     = diff[clm3_pkg::WORD_BITS-1:0];
                    bad_next   = bad_reg || qovf_reg || sub_ovf;
                    k_next     = k_reg + 2'd1;
                    state_next = clm3_pkg::S_MUL_LO;
                end
                else
                begin
                    nxt_next[var_reg] = new_val;
                    nv_next[var_reg]  = keep;
                    if (var_reg == clm3_pkg::LAST_VAR)
                    begin
                        // Commit all three new values together.
                        for (int v = 0; v < clm3_pkg::VAR_COUNT; v++)
                        begin
                            x_next[v] = (clm3_pkg::VIDX_W'(v) == var_reg) ? new_val
                                                                         : nxt_reg[v];
                        end
                        vb_next    = nv_next;
                        state_next = clm3_pkg::S_OUT;
                    end
                    else
                    begin
                        var_next   = var_reg + 1'b1;
                        k_next     = clm3_pkg::TERM_ALPHA;
                        state_next = clm3_pkg::S_MUL_LO;
                    end
                end
            end

            clm3_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.value_first  = x_reg[0];
                    out_data_next.value_second = x_reg[1];
                    out_data_next.value_third  = x_reg[2];
                    out_data_next.valid_mask   = vb_reg;
                    state_next                 = clm3_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = clm3_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clm3_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_reg       <= '0;
            k_reg         <= clm3_pkg::TERM_ALPHA;
            bad_reg       <= 1'b0;
            nv_reg        <= '0;
            vb_reg        <= clm3_pkg::ALL_VALID;
            esc_reg       <= '1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < clm3_pkg::COEF_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
            for (int i = 0; i < clm3_pkg::VAR_COUNT; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else
        begin
            var_reg       <= var_next;
            k_reg         <= k_next;
            bad_reg       <= bad_next;
            nv_reg        <= nv_next;
            vb_reg        <= vb_next;
            out_valid_reg <= out_valid_next;
            coef_reg      <= coef_next;
            x_reg         <= x_next;
            if (cfg_valid && cfg_ready)
            begin
                esc_reg <= cfg_data;
            end
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        lo_reg       <= lo_next;
        q_reg        <= q_next;
        qovf_reg     <= qovf_next;
        t_reg        <= t_next;
        nxt_reg      <= nxt_next;
        out_data_reg <= out_data_next;
    end

    // Checks.
    `CLM3_ASSERT_SAME(a_invalid_is_zero, 1'b1,
        (vb_reg[0] || x_reg[0] == '0) && (vb_reg[1] || x_reg[1] == '0)
            && (vb_reg[2] || x_reg[2] == '0),
        "invalid variable holds a nonzero value")
    `CLM3_ASSERT_NEXT(a_step_starts,
        in_valid && !in_stall && in_data.mode == clm3_pkg::MODE_STEP
            && vb_reg == clm3_pkg::ALL_VALID,
        state_reg == clm3_pkg::S_MUL_LO,
        "step did not start the multiply sequence")
    `CLM3_ASSERT_NEXT(a_last_commit,
        state_reg == clm3_pkg::S_APPLY && k_reg == clm3_pkg::TERM_OUTER
            && var_reg == clm3_pkg::LAST_VAR,
        state_reg == clm3_pkg::S_OUT,
        "last variable did not lead to the result")
    `CLM3_ASSERT_SAME(a_result_source, $rose(out_valid),
        $past(state_reg == clm3_pkg::S_OUT),
        "result loaded outside the output state")

endmodule

### sim/coupled_logistic_map_three_top_tb.sv
// ============================================================================
// Coupled logistic map, three variables: self-checking testbench
// Drives coefficient writes, start-value loads, steps and ignored items into
// the block. The escape limit changes between phases, and both sides idle at
// random. A scoreboard keeps its own copy of the map state and predicts each
// result in fixed point. Every output transfer is checked field by field
// against the oldest prediction.
// ============================================================================
module coupled_logistic_map_three_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode with no effect on the state.
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Fixed-point constants, 32 fractional bits.
    localparam clm3_pkg::word_t FX_QUARTER = clm3_pkg::word_t'(64'h0000_4000_0000);
    localparam clm3_pkg::word_t FX_HALF    = clm3_pkg::word_t'(64'h0000_8000_0000);
    localparam clm3_pkg::word_t FX_ONE     = clm3_pkg::word_t'(64'h0001_0000_0000);
    localparam clm3_pkg::word_t FX_THREE   = clm3_pkg::word_t'(64'h0003_0000_0000);
    localparam clm3_pkg::word_t FX_A325    = clm3_pkg::word_t'(64'h0003_4000_0000);
    localparam clm3_pkg::word_t FX_A350    = clm3_pkg::word_t'(64'h0003_8000_0000);
    localparam clm3_pkg::word_t FX_A375    = clm3_pkg::word_t'(64'h0003_C000_0000);
    localparam clm3_pkg::word_t FX_B100    = clm3_pkg::word_t'(64'h0000_1999_999A);
    localparam clm3_pkg::word_t FX_B050    = clm3_pkg::word_t'(64'h0000_0CCC_CCCD);
    localparam clm3_pkg::word_t WORD_MAX   = clm3_pkg::word_t'(64'h0000_7FFF_FFFF_FFFF);
    localparam clm3_pkg::word_t WORD_MIN   = clm3_pkg::word_t'(64'h0000_8000_0000_0000);

    // Coefficients and peers that feed each variable.
    localparam logic [clm3_pkg::CIDX_W-1:0] ALPHA_OF [clm3_pkg::VAR_COUNT] =
        '{clm3_pkg::C_ALPHA1, clm3_pkg::C_ALPHA2, clm3_pkg::C_ALPHA3};
    localparam logic [clm3_pkg::CIDX_W-1:0] BETA_J_OF [clm3_pkg::VAR_COUNT] =
        '{clm3_pkg::C_BETA21, clm3_pkg::C_BETA12, clm3_pkg::C_BETA13};
    localparam logic [clm3_pkg::CIDX_W-1:0] BETA_K_OF [clm3_pkg::VAR_COUNT] =
        '{clm3_pkg::C_BETA31, clm3_pkg::C_BETA32, clm3_pkg::C_BETA23};
    localparam int PEER_J [clm3_pkg::VAR_COUNT] = '{1, 0, 0};
    localparam int PEER_K [clm3_pkg::VAR_COUNT] = '{2, 2, 1};

    // Items per random phase, counting only items that affect the state.
    localparam int PHASE_ITEMS = 400;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    clm3_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    clm3_pkg::out_item_t             out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [clm3_pkg::LIMIT_BITS-1:0] cfg_data  = '0;

    // When set, neither side inserts random idle cycles; the two long result hold-offs still apply.
    bit calm = 1'b0;
    int items_sent = 0;

    coupled_logistic_map_three_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Map state tracker and result checker.
    class clm3_scoreboard;
        clm3_pkg::word_t                 coefs [clm3_pkg::COEF_COUNT];
        clm3_pkg::word_t                 vals [clm3_pkg::VAR_COUNT];
        logic [2:0]                      vmask;
        logic [clm3_pkg::LIMIT_BITS-1:0] limit;
        bit                              overflow;
        clm3_pkg::out_item_t             states_due [$];
        int                              errors;
        int                              results_seen;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            foreach (vals[i]) vals[i] = '0;
            vmask        = clm3_pkg::ALL_VALID;
            limit        = '1;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_limit(logic [clm3_pkg::LIMIT_BITS-1:0] v);
            limit = v;
        endfunction

        // Exact product, floored to the value format; flags results that do not fit.
        function clm3_pkg::word_t fx_mul(clm3_pkg::word_t a, clm3_pkg::word_t b);
            logic signed [2*clm3_pkg::WORD_BITS-1:0] wa;
            logic signed [2*clm3_pkg::WORD_BITS-1:0] wb;
            logic signed [2*clm3_pkg::WORD_BITS-1:0] prod;
            wa   = {{clm3_pkg::WORD_BITS{a[clm3_pkg::WORD_BITS-1]}}, a};
            wb   = {{clm3_pkg::WORD_BITS{b[clm3_pkg::WORD_BITS-1]}}, b};
            prod = (wa * wb) >>> clm3_pkg::FRACTION_BITS;
            if (prod[2*clm3_pkg::WORD_BITS-1:clm3_pkg::WORD_BITS-1]
                != {(clm3_pkg::WORD_BITS+1){prod[clm3_pkg::WORD_BITS-1]}})
                overflow = 1'b1;
            return prod[clm3_pkg::WORD_BITS-1:0];
        endfunction

        function clm3_pkg::word_t fx_sub(clm3_pkg::word_t a, clm3_pkg::word_t b);
            logic signed [clm3_pkg::WORD_BITS:0] d;
            d = {a[clm3_pkg::WORD_BITS-1], a} - {b[clm3_pkg::WORD_BITS-1], b};
            if (d[clm3_pkg::WORD_BITS] != d[clm3_pkg::WORD_BITS-1])
                overflow = 1'b1;
            return d[clm3_pkg::WORD_BITS-1:0];
        endfunction

        // One step of the map; any invalid variable invalidates all three.
        function void advance_map();
            clm3_pkg::word_t                nxt [clm3_pkg::VAR_COUNT];
            logic [2:0]                     nv;
            clm3_pkg::word_t                t;
            clm3_pkg::word_t                r;
            clm3_pkg::word_t                p;
            logic [clm3_pkg::WORD_BITS-1:0] mag;
            nv = '0;
            foreach (nxt[i]) nxt[i] = '0;
            if (vmask == clm3_pkg::ALL_VALID)
            begin
                for (int i = 0; i < clm3_pkg::VAR_COUNT; i++)
                begin
                    overflow = 1'b0;
                    t = coefs[ALPHA_OF[i]];
                    p = fx_mul(coefs[ALPHA_OF[i]], vals[i]);
                    t = fx_sub(t, p);
                    p = fx_mul(coefs[BETA_J_OF[i]], vals[PEER_J[i]]);
                    t = fx_sub(t, p);
                    p = fx_mul(coefs[BETA_K_OF[i]], vals[PEER_K[i]]);
                    t = fx_sub(t, p);
                    r = fx_mul(vals[i], t);
                    mag = r[clm3_pkg::WORD_BITS-1] ? -r : r;
                    if (!overflow && mag <= {1'b0, limit})
                    begin
                        nxt[i] = r;
                        nv[i]  = 1'b1;
                    end
                end
            end
            vals  = nxt;
            vmask = nv;
        endfunction

        // Applies an accepted item and queues the state it leaves behind.
        function void note_item(clm3_pkg::in_item_t it);
            clm3_pkg::out_item_t want;
            case (it.mode)
                clm3_pkg::MODE_COEF:
                    if (it.coef_index < clm3_pkg::CIDX_W'(clm3_pkg::COEF_COUNT))
                        coefs[it.coef_index] = it.coef_value;
                clm3_pkg::MODE_LOAD:
                begin
                    vals[0] = it.start_valid[0] ? it.start_first  : '0;
                    vals[1] = it.start_valid[1] ? it.start_second : '0;
                    vals[2] = it.start_valid[2] ? it.start_third  : '0;
                    vmask   = it.start_valid;
                end
                clm3_pkg::MODE_STEP:
                    advance_map();
                default:
                    ;
            endcase
            want.value_first  = vals[0];
            want.value_second = vals[1];
            want.value_third  = vals[2];
            want.valid_mask   = vmask;
            states_due.push_back(want);
        endfunction

        task report(string what, logic [clm3_pkg::WORD_BITS-1:0] got,
                    logic [clm3_pkg::WORD_BITS-1:0] want);
            errors++;
            if (errors <= 40)
                $display("%0t: result %0d, %s: got %h, expected %h",
                         $time, results_seen, what, got, want);
        endtask

        task check_result(clm3_pkg::out_item_t got);
            clm3_pkg::out_item_t want;
            results_seen++;
            if (states_due.size() == 0)
            begin
                report("result with no item pending", '0, '0);
                return;
            end
            want = states_due.pop_front();
            if (got.value_first !== want.value_first)
                report("value_first", got.value_first, want.value_first);
            if (got.value_second !== want.value_second)
                report("value_second", got.value_second, want.value_second);
            if (got.value_third !== want.value_third)
                report("value_third", got.value_third, want.value_third);
            if (got.valid_mask !== want.valid_mask)
                report("valid_mask",
                       {{(clm3_pkg::WORD_BITS-3){1'b0}}, got.valid_mask},
                       {{(clm3_pkg::WORD_BITS-3){1'b0}}, want.valid_mask});
        endtask
    endclass

    clm3_scoreboard sb = new();

    // Clock, 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watch all three channels and feed the scoreboard on every transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_limit(cfg_data);
            if (in_valid && !in_stall)
                sb.note_item(in_data);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
        end
    end

    // Item builders; fields that the mode ignores carry random bits.
    function automatic clm3_pkg::word_t rand_word();
        return clm3_pkg::word_t'({$urandom, $urandom});
    endfunction

    function automatic clm3_pkg::word_t rand_unit();
        return clm3_pkg::word_t'({32'h0, $urandom});
    endfunction

    function automatic clm3_pkg::word_t rand_alpha();
        return FX_THREE + rand_unit();
    endfunction

    function automatic clm3_pkg::word_t rand_beta();
        return clm3_pkg::word_t'(int'($urandom)) >>> 3;
    endfunction

    function automatic clm3_pkg::in_item_t noise_item();
        clm3_pkg::in_item_t it;
        it.mode         = 2'($urandom);
        it.coef_index   = clm3_pkg::CIDX_W'($urandom);
        it.coef_value   = rand_word();
        it.start_first  = rand_word();
        it.start_second = rand_word();
        it.start_third  = rand_word();
        it.start_valid  = 3'($urandom);
        return it;
    endfunction

    function automatic clm3_pkg::in_item_t make_item(logic [1:0] mode);
        clm3_pkg::in_item_t it;
        it      = noise_item();
        it.mode = mode;
        return it;
    endfunction

    function automatic clm3_pkg::in_item_t coef_item(logic [clm3_pkg::CIDX_W-1:0] idx,
                                                     clm3_pkg::word_t v);
        clm3_pkg::in_item_t it;
        it            = make_item(clm3_pkg::MODE_COEF);
        it.coef_index = idx;
        it.coef_value = v;
        return it;
    endfunction

    function automatic clm3_pkg::in_item_t load_item(logic [2:0] vm, clm3_pkg::word_t a,
                                                     clm3_pkg::word_t b, clm3_pkg::word_t c);
        clm3_pkg::in_item_t it;
        it              = make_item(clm3_pkg::MODE_LOAD);
        it.start_valid  = vm;
        it.start_first  = a;
        it.start_second = b;
        it.start_third  = c;
        return it;
    endfunction

    // Picks a random coefficient value suited to the slot.
    function automatic clm3_pkg::word_t rand_coef(logic [clm3_pkg::CIDX_W-1:0] idx);
        return (idx < clm3_pkg::C_BETA12) ? rand_alpha() : rand_beta();
    endfunction

    // Offers one item after a random gap and returns at its transfer.
    task automatic send_item(input clm3_pkg::in_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (it.mode != MODE_NONE
            && !(it.mode == clm3_pkg::MODE_COEF
                 && it.coef_index >= clm3_pkg::CIDX_W'(clm3_pkg::COEF_COUNT)))
            items_sent++;
    endtask

    // Lets every pending result drain so the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.states_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [clm3_pkg::LIMIT_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // Step from the reset state, then items that must change nothing.
        send_item(make_item(clm3_pkg::MODE_STEP));
        send_item(make_item(MODE_NONE));
        send_item(coef_item(clm3_pkg::CIDX_W'(clm3_pkg::COEF_COUNT), WORD_MAX));
        send_item(coef_item('1, WORD_MIN));
        // Full table, with the extremes on the third variable.
        send_item(coef_item(clm3_pkg::C_ALPHA1, FX_A375));
        send_item(coef_item(clm3_pkg::C_ALPHA2, FX_A350));
        send_item(coef_item(clm3_pkg::C_ALPHA3, WORD_MAX));
        send_item(coef_item(clm3_pkg::C_BETA12, FX_B100));
        send_item(coef_item(clm3_pkg::C_BETA13, WORD_MIN));
        send_item(coef_item(clm3_pkg::C_BETA21, FX_B050));
        send_item(coef_item(clm3_pkg::C_BETA23, -FX_B050));
        send_item(coef_item(clm3_pkg::C_BETA31, FX_B050));
        send_item(coef_item(clm3_pkg::C_BETA32, FX_B100));
        // The third variable overflows, and then all three go invalid.
        send_item(load_item(clm3_pkg::ALL_VALID, FX_HALF, FX_QUARTER, '0));
        send_item(make_item(clm3_pkg::MODE_STEP));
        send_item(make_item(clm3_pkg::MODE_STEP));
        send_item(make_item(clm3_pkg::MODE_STEP));
        // Invalid start values are stored as zero.
        send_item(load_item(3'b000, WORD_MAX, WORD_MAX, WORD_MAX));
        send_item(load_item(3'b101, WORD_MAX, WORD_MAX, WORD_MIN));
        // Extreme start values overflow the products.
        send_item(load_item(clm3_pkg::ALL_VALID, WORD_MAX, WORD_MIN, '1));
        send_item(make_item(clm3_pkg::MODE_STEP));
        // A sane table and a well-behaved orbit.
        send_item(coef_item(clm3_pkg::C_ALPHA3, FX_A325));
        send_item(coef_item(clm3_pkg::C_BETA13, '0));
        send_item(load_item(clm3_pkg::ALL_VALID, FX_HALF, FX_HALF, FX_HALF));
        send_item(make_item(clm3_pkg::MODE_STEP));
    endtask

    // One random sequence; most are coefficient setup, a load and an orbit.
    task automatic run_sequence();
        int kind;
        int c;
        kind = $urandom_range(0, 9);
        calm = ($urandom_range(0, 7) == 0);
        if (kind <= 5)
        begin
            if ($urandom_range(0, 1))
            begin
                for (c = 0; c < clm3_pkg::COEF_COUNT; c++)
                    send_item(coef_item(clm3_pkg::CIDX_W'(c),
                                        rand_coef(clm3_pkg::CIDX_W'(c))));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    c = $urandom_range(0, clm3_pkg::COEF_COUNT - 1);
                    send_item(coef_item(clm3_pkg::CIDX_W'(c),
                                        rand_coef(clm3_pkg::CIDX_W'(c))));
                end
            end
            send_item(load_item(clm3_pkg::ALL_VALID, rand_unit(), rand_unit(), rand_unit()));
            repeat ($urandom_range(4, 30)) send_item(make_item(clm3_pkg::MODE_STEP));
        end
        else if (kind == 6)
        begin
            repeat ($urandom_range(1, 4)) send_item(noise_item());
        end
        else if (kind == 7)
        begin
            send_item(load_item(3'($urandom), rand_word(), rand_word(), rand_word()));
            repeat ($urandom_range(1, 3)) send_item(make_item(clm3_pkg::MODE_STEP));
        end
        else if (kind == 8)
        begin
            send_item(coef_item(clm3_pkg::CIDX_W'($urandom_range(0, clm3_pkg::COEF_COUNT - 1)),
                                rand_word()));
            send_item(load_item(clm3_pkg::ALL_VALID, rand_unit(), rand_unit(), rand_unit()));
            repeat ($urandom_range(2, 6)) send_item(make_item(clm3_pkg::MODE_STEP));
        end
        else
        begin
            send_item(load_item(clm3_pkg::ALL_VALID, rand_word(), rand_word(), rand_word()));
            repeat ($urandom_range(1, 2)) send_item(make_item(clm3_pkg::MODE_STEP));
        end
    endtask

    // Result side: random stalls per transfer, and two long hold-offs that
    // back the block up into its input.
    initial
    begin : drain_results
        int taken;
        int n;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 10);
            if (taken == 40 || taken == 900)
                n = 400;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Main sequence: reset, directed items, then random phases with
    // different escape limits.
    initial
    begin : main_flow
        logic [clm3_pkg::LIMIT_BITS-1:0] limits [5];
        int target;
        limits[0] = '1;
        limits[1] = '0;
        limits[2] = clm3_pkg::LIMIT_BITS'({$urandom_range(0, 3), $urandom});
        limits[3] = clm3_pkg::LIMIT_BITS'({$urandom, $urandom});
        limits[4] = clm3_pkg::LIMIT_BITS'(FX_ONE);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        foreach (limits[p])
        begin
            settle();
            write_limit(limits[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_sequence();
        end
        settle();
        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit for the whole simulation.
    initial
    begin
        #8ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/clm3_pkg.sv
hdl/coupled_logistic_map_three_top.sv
sim/coupled_logistic_map_three_top_tb.sv
